// File: rtl/core/spct_pkg.sv
package spct_pkg;

    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_SPHERE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CUBE   = 2'd1;

    localparam int AXES = 3;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SS,
        MODE_SC,
        MODE_CC
    } pair_mode_t;

endpackage

// File: rtl/core/spct_if.sv
interface spct_in_if #(
    parameter int POS_WIDTH = 24
);
    import spct_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [KIND_W-1:0]           kind;
    logic [KIND_W-1:0]           other_kind;
    logic signed [POS_WIDTH-1:0] first_x;
    logic signed [POS_WIDTH-1:0] first_y;
    logic signed [POS_WIDTH-1:0] first_z;
    logic signed [POS_WIDTH-1:0] second_x;
    logic signed [POS_WIDTH-1:0] second_y;
    logic signed [POS_WIDTH-1:0] second_z;

    modport source (
        output valid, kind, other_kind,
        output first_x, first_y, first_z, second_x, second_y, second_z,
        input  ready
    );

    modport sink (
        input  valid, kind, other_kind,
        input  first_x, first_y, first_z, second_x, second_y, second_z,
        output ready
    );
endinterface

interface spct_out_if;
    logic valid;
    logic ready;
    logic colliding;

    modport source (
        output valid, colliding,
        input  ready
    );

    modport sink (
        input  valid, colliding,
        output ready
    );
endinterface

// File: rtl/core/shape_pair_collision_test_core.sv
// Shape pair collision test.
// Channel pair (sink) takes one beat per object pair: two shape kinds
// (sphere, cube, or none) and two signed fixed-point centres. Channel
// result (source) returns one beat per pair, colliding set when the shapes
// touch or overlap. Beats come out in the order they went in.
// Throughput: one pair per cycle while result does not stall; four register
// stages (axis difference, magnitude and clamp, squaring, sum and compare),
// one multiplier per axis, with result.valid driven from the fourth stage.
// Each stage takes a new beat when empty or when the next stage moves on,
// so a stall on result backs up stage by stage and pair.ready falls only
// once all four stages hold a beat. Nothing is dropped or repeated.
// Reset empties the pipeline: result.valid is low and pair.ready is high
// while rst_n is low. The pair interface must carry the same POS_WIDTH as
// this module; FRAC_BITS must stay below POS_WIDTH.
module shape_pair_collision_test_core
    import spct_pkg::*;
#(
    parameter int POS_WIDTH = 24,
    parameter int FRAC_BITS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    spct_in_if.sink   pair,
    spct_out_if.source result
);

    localparam int DW   = POS_WIDTH + 1;
    localparam int OPW  = FRAC_BITS + 1;
    localparam int SQW  = 2 * OPW;
    localparam int SUMW = SQW + 2;

    localparam logic [DW-1:0]   ONE_FX     = DW'(1) << FRAC_BITS;
    localparam logic [DW-1:0]   HALF_FX    = DW'(1) << (FRAC_BITS - 1);
    localparam logic [SUMW-1:0] ONE_SQ     = SUMW'(1) << (2 * FRAC_BITS);
    localparam logic [SUMW-1:0] QUARTER_SQ = SUMW'(1) << (2 * FRAC_BITS - 2);

    // stage valid bits and per-stage ready
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !s4_v_reg || result.ready;
    assign rdy3 = !s3_v_reg || rdy4;
    assign rdy2 = !s2_v_reg || rdy3;
    assign rdy1 = !s1_v_reg || rdy2;

    assign pair.ready = rdy1;

    // stage 1: axis differences and pair decode
    logic signed [POS_WIDTH-1:0] pos_a [AXES];
    logic signed [POS_WIDTH-1:0] pos_b [AXES];
    logic signed [DW-1:0]        s1_d_next [AXES];
    logic signed [DW-1:0]        s1_d_reg  [AXES];
    pair_mode_t                  s1_mode_next, s1_mode_reg;

    assign pos_a[0] = POS_WIDTH'(pair.first_x);
    assign pos_a[1] = POS_WIDTH'(pair.first_y);
    assign pos_a[2] = POS_WIDTH'(pair.first_z);
    assign pos_b[0] = POS_WIDTH'(pair.second_x);
    assign pos_b[1] = POS_WIDTH'(pair.second_y);
    assign pos_b[2] = POS_WIDTH'(pair.second_z);

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            s1_d_next[i] = DW'(pos_a[i]) - DW'(pos_b[i]);
        end
    end

    always_comb
    begin
        priority if (pair.kind == KIND_SPHERE && pair.other_kind == KIND_SPHERE)
            s1_mode_next = MODE_SS;
        else if ((pair.kind == KIND_SPHERE && pair.other_kind == KIND_CUBE) ||
                 (pair.kind == KIND_CUBE && pair.other_kind == KIND_SPHERE))
            s1_mode_next = MODE_SC;
        else if (pair.kind == KIND_CUBE && pair.other_kind == KIND_CUBE)
            s1_mode_next = MODE_CC;
        else
            s1_mode_next = MODE_NONE;
    end

    // stage 2: magnitude, reach check, clamp gap
    logic [DW-1:0]  mag [AXES];
    logic [DW-1:0]  gap [AXES];
    logic [OPW-1:0] s2_op_next [AXES];
    logic [OPW-1:0] s2_op_reg  [AXES];
    logic           s2_near_next, s2_near_reg;
    pair_mode_t     s2_mode_reg;

    always_comb
    begin
        s2_near_next = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            mag[i] = s1_d_reg[i][DW-1] ? DW'(-s1_d_reg[i]) : DW'(s1_d_reg[i]);
            gap[i] = (mag[i] > HALF_FX) ? (mag[i] - HALF_FX) : '0;
            if (mag[i] > ONE_FX)
            begin
                s2_near_next = 1'b0;
            end
            s2_op_next[i] = (s1_mode_reg == MODE_SS) ? mag[i][OPW-1:0] : gap[i][OPW-1:0];
        end
    end

    // stage 3: squares
    logic [SQW-1:0] s3_sq_next [AXES];
    logic [SQW-1:0] s3_sq_reg  [AXES];
    logic           s3_near_reg;
    pair_mode_t     s3_mode_reg;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            s3_sq_next[i] = SQW'(s2_op_reg[i]) * SQW'(s2_op_reg[i]);
        end
    end

    // stage 4: sum and compare
    logic [SUMW-1:0] sum;
    logic [SUMW-1:0] limit;
    logic            hit_next, hit_reg;

    always_comb
    begin
        sum   = SUMW'(s3_sq_reg[0]) + SUMW'(s3_sq_reg[1]) + SUMW'(s3_sq_reg[2]);
        limit = (s3_mode_reg == MODE_SS) ? ONE_SQ : QUARTER_SQ;
        unique case (s3_mode_reg)
            MODE_SS, MODE_SC: hit_next = s3_near_reg && (sum <= limit);
            MODE_CC:          hit_next = s3_near_reg;
            default:          hit_next = 1'b0;
        endcase
    end

    assign result.valid     = s4_v_reg;
    assign result.colliding = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_v_reg <= pair.valid;
            end
            if (rdy2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (rdy3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (rdy4)
            begin
                s4_v_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_d_reg    <= s1_d_next;
            s1_mode_reg <= s1_mode_next;
        end
        if (rdy2)
        begin
            s2_op_reg   <= s2_op_next;
            s2_near_reg <= s2_near_next;
            s2_mode_reg <= s1_mode_reg;
        end
        if (rdy3)
        begin
            s3_sq_reg   <= s3_sq_next;
            s3_near_reg <= s2_near_reg;
            s3_mode_reg <= s2_mode_reg;
        end
        if (rdy4)
        begin
            hit_reg <= hit_next;
        end
    end

    // clamped operands stay within one unit when the pair is in reach
    a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg && s2_near_reg |->
            (DW'(s2_op_reg[0]) <= ONE_FX) && (DW'(s2_op_reg[1]) <= ONE_FX) &&
            (DW'(s2_op_reg[2]) <= ONE_FX))
        else $error("squaring operand out of range");

    // a held beat in stage 3 keeps its squares while the output stalls
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg && !rdy4 |=>
            $stable(s3_sq_reg[0]) && $stable(s3_sq_reg[1]) && $stable(s3_sq_reg[2]))
        else $error("stage 3 changed under stall");

    // an output beat only appears from a beat that was in stage 3
    a_s4_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s4_v_reg) |-> $past(s3_v_reg))
        else $error("output beat without a stage 3 beat");

endmodule
